/* rtl/per_node_replay_filter_defines.svh */
// Assertion macros shared by the replay filter RTL.
`ifndef PER_NODE_REPLAY_FILTER_DEFINES_SVH
`define PER_NODE_REPLAY_FILTER_DEFINES_SVH

// Checks an implication on every clock edge outside reset.
`define RPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks a plain invariant on every clock edge outside reset.
`define RPF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

/* rtl/rpf_pkg.sv */
// Shared constants and types of the per-node replay filter.
package rpf_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned NODE_W = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned WIN_W  = 24;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60000);

  typedef enum logic [1:0] {
    V_NEW     = 2'd0,
    V_UPDATED = 2'd1,
    V_OUTSIDE = 2'd2,
    V_REPLAY  = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] last_time;
  } entry_t;

  // Write request into the node table.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

/* rtl/per_node_replay_filter.sv */
// Top level of the per-node replay filter: sequencer, registers and ports.
//
//  channel | direction | request moves
//  s_axis  | in        | sender id, message time, current time
//  m_axis  | out       | accepted flag and verdict
//  cfg     | in        | window_ms register write
//
// An item is checked against the upper, then the lower edge of the window; one
// outside it goes straight to the result, any other through the entry scan: one
// table read and one compare in the shared comparator per entry. A finished result
// waits in the output register; the sequencer holds its last step until that
// register is free. Reset empties the table at once and loads the window with 60000.
`include "per_node_replay_filter_defines.svh"

module per_node_replay_filter
  import rpf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // sender_id[31:0], msg_time_ms[79:32], now_time_ms[127:80]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,  // accepted[0], verdict[2:1], zero[7:3]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [23:0]  cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HI   = 7'b0000010,
    S_LO   = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_INS  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [TIME_W-1:0] msg_q, msg_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  oldest_q, oldest_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  verdict_e          verd_q, verd_d;
  logic              out_valid_q, out_valid_d;
  verdict_e          out_verd_q, out_verd_d;

  logic [TIME_W-1:0] cmp_a, cmp_b;
  logic [WIN_W-1:0]  cmp_ofs;
  logic              cmp_gt;
  tbl_wr_t           tbl_wr;
  entry_t            tbl_rdata;
  logic [IDX_W:0]    slot_sum;
  logic [IDX_W-1:0]  scan_slot;
  logic [IDX_W-1:0]  ins_slot;
  logic              full;
  logic              out_free;

  rpf_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .ofs_i(cmp_ofs),
    .gt_o (cmp_gt)
  );

  rpf_table u_table (
    .clk_i  (clk_i),
    .wr_i   (tbl_wr),
    .raddr_i(slot_d),
    .rdata_o(tbl_rdata)
  );

  assign full     = (cnt_q == CNT_W'(TABLE_ENTRIES));
  assign out_free = !out_valid_q || m_axis_tready;

  // Slot of the k-th oldest entry, or of the first free entry when k equals the count and the table is not full.
  assign slot_sum  = {1'b0, oldest_q} + (IDX_W + 1)'(k_q);
  assign scan_slot = (slot_sum >= (IDX_W + 1)'(TABLE_ENTRIES)) ?
                     IDX_W'(slot_sum - (IDX_W + 1)'(TABLE_ENTRIES)) : slot_sum[IDX_W-1:0];
  assign ins_slot  = full ? oldest_q : scan_slot;

  // Operand selection for the shared comparator.
  always_comb begin
    cmp_a   = msg_q;
    cmp_b   = now_q;
    cmp_ofs = win_q;
    unique case (state_q)
      S_LO: begin
        // Below the window when now > msg + window; this also clamps the bound at zero.
        cmp_a = now_q;
        cmp_b = msg_q;
      end
      S_CMP: begin
        cmp_b   = tbl_rdata.last_time;
        cmp_ofs = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    node_d      = node_q;
    msg_d       = msg_q;
    now_d       = now_q;
    cnt_d       = cnt_q;
    oldest_d    = oldest_q;
    k_d         = k_q;
    slot_d      = slot_q;
    verd_d      = verd_q;
    out_valid_d = out_valid_q;
    out_verd_d  = out_verd_q;
    tbl_wr      = '0;

    if (cfg_valid_i) begin
      win_d = cfg_data_i;
    end
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          node_d  = s_axis_tdata[31:0];
          msg_d   = s_axis_tdata[79:32];
          now_d   = s_axis_tdata[127:80];
          state_d = S_HI;
        end
      end
      S_HI: begin
        if (cmp_gt) begin
          verd_d  = V_OUTSIDE;
          state_d = S_EMIT;
        end else begin
          state_d = S_LO;
        end
      end
      S_LO: begin
        if (cmp_gt) begin
          verd_d  = V_OUTSIDE;
          state_d = S_EMIT;
        end else begin
          k_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (k_q == cnt_q) begin
          state_d = S_INS;
        end else begin
          slot_d  = scan_slot;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (tbl_rdata.node == node_q) begin
          if (cmp_gt) begin
            tbl_wr.we             = 1'b1;
            tbl_wr.addr           = slot_q;
            tbl_wr.data.node      = node_q;
            tbl_wr.data.last_time = msg_q;
            verd_d                = V_UPDATED;
          end else begin
            verd_d = V_REPLAY;
          end
          state_d = S_EMIT;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_RD;
        end
      end
      S_INS: begin
        tbl_wr.we             = 1'b1;
        tbl_wr.addr           = ins_slot;
        tbl_wr.data.node      = node_q;
        tbl_wr.data.last_time = msg_q;
        if (full) begin
          oldest_d = (oldest_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : oldest_q + IDX_W'(1);
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        verd_d  = V_NEW;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_verd_d  = verd_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= WINDOW_RESET;
      cnt_q       <= '0;
      oldest_q    <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      oldest_q    <= oldest_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    msg_q      <= msg_d;
    now_q      <= now_d;
    slot_q     <= slot_d;
    verd_q     <= verd_d;
    out_verd_q <= out_verd_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_verd_q,
                          (out_verd_q == V_NEW) || (out_verd_q == V_UPDATED)};

  `RPF_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(TABLE_ENTRIES), "entry count above table size")
  `RPF_ASSERT_IMPL(a_oldest_full, oldest_q != '0, full, "oldest slot moved before table filled")
  `RPF_ASSERT_IMPL(a_scan_bound, state_q == S_CMP, k_q < cnt_q, "scan read beyond entries in use")
  `RPF_ASSERT_IMPL(a_out_hold, m_axis_tvalid && !m_axis_tready, ##1 $stable(m_axis_tdata),
                   "stalled result changed")

endmodule

/* rtl/rpf_cmp.sv */
// Shared magnitude comparator: tells whether a is greater than b plus an offset.
module rpf_cmp
  import rpf_pkg::*;
(
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  input  logic [WIN_W-1:0]  ofs_i,
  output logic              gt_o
);

  logic [TIME_W:0] sum;

  // One extra bit keeps b plus the window from wrapping.
  assign sum  = {1'b0, b_i} + {{(TIME_W + 1 - WIN_W){1'b0}}, ofs_i};
  assign gt_o = {1'b0, a_i} > sum;

endmodule

/* rtl/rpf_table.sv */
// Node table memory: one write port and one registered read port.
module rpf_table
  import rpf_pkg::*;
(
  input  logic             clk_i,
  input  tbl_wr_t          wr_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
